// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file llint_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define AST_NXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/llint_pkg.sv -----
// shared types and constants for the line intersection pipeline
// no dependencies; used by every module of the block
package llint_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COEF_WIDTH_DEF = 32;
    localparam int TOL_WIDTH      = 32;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd1;

    typedef enum logic [1:0] {
        ST_POINT      = 2'd0,
        ST_PARALLEL   = 2'd1,
        ST_COINCIDENT = 2'd2
    } t_status;

    // per-item sideband that travels alongside the divider data
    typedef struct packed {
        t_status status;
        logic    neg_x;
        logic    neg_y;
        logic    sat_x;
        logic    sat_y;
    } t_side;

endpackage

// ----- rtl/core/llint_front.sv -----
// front stages: six products, the three cramer differences, magnitudes,
// tolerance tests and divider set-up; depends on llint_pkg
module llint_front #(
    parameter int COEF_WIDTH = llint_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = llint_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic [3:0]                        i_en,
    input  logic signed [COEF_WIDTH-1:0]      i_a1,
    input  logic signed [COEF_WIDTH-1:0]      i_b1,
    input  logic signed [COEF_WIDTH-1:0]      i_c1,
    input  logic signed [COEF_WIDTH-1:0]      i_a2,
    input  logic signed [COEF_WIDTH-1:0]      i_b2,
    input  logic signed [COEF_WIDTH-1:0]      i_c2,
    input  logic [llint_pkg::TOL_WIDTH-1:0]   i_tol,
    output llint_pkg::t_side                  o_side,
    output logic [2*COEF_WIDTH:0]             o_den,
    output logic [2*COEF_WIDTH:0]             o_rem_x,
    output logic [2*COEF_WIDTH:0]             o_rem_y,
    output logic [COEF_WIDTH:0]               o_nlow_x,
    output logic [COEF_WIDTH:0]               o_nlow_y
);

    localparam int PW = 2 * COEF_WIDTH;
    localparam int DW = PW + 1;
    localparam int NW = DW + FRAC_BITS;
    localparam int CW = (DW > llint_pkg::TOL_WIDTH) ? DW : llint_pkg::TOL_WIDTH;

    // stage 0: products
    logic signed [PW-1:0] r_p_a1b2, r_p_b1a2, r_p_b1c2, r_p_c1b2, r_p_a2c1, r_p_a1c2;
    // stage 1: determinant and numerators
    logic signed [DW-1:0] r_det, r_nx, r_ny;
    // stage 2: magnitudes and quotient signs
    logic [DW-1:0]        r_mag_det, r_mag_x, r_mag_y;
    logic                 r_neg_x, r_neg_y;
    // stage 3: divider set-up
    llint_pkg::t_side     r_side;
    logic [DW-1:0]        r_den, r_rem_x, r_rem_y;
    logic [COEF_WIDTH:0]  r_nlow_x, r_nlow_y;

    logic [NW-1:0]        n_sh_x, n_sh_y, n_top_x, n_top_y, n_den_w;
    logic                 n_flat, n_coin;
    llint_pkg::t_side     n_side;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p_a1b2 <= PW'(i_a1) * PW'(i_b2);
            r_p_b1a2 <= PW'(i_b1) * PW'(i_a2);
            r_p_b1c2 <= PW'(i_b1) * PW'(i_c2);
            r_p_c1b2 <= PW'(i_c1) * PW'(i_b2);
            r_p_a2c1 <= PW'(i_a2) * PW'(i_c1);
            r_p_a1c2 <= PW'(i_a1) * PW'(i_c2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_det <= {r_p_a1b2[PW-1], r_p_a1b2} - {r_p_b1a2[PW-1], r_p_b1a2};
            r_nx  <= {r_p_b1c2[PW-1], r_p_b1c2} - {r_p_c1b2[PW-1], r_p_c1b2};
            r_ny  <= {r_p_a2c1[PW-1], r_p_a2c1} - {r_p_a1c2[PW-1], r_p_a1c2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_mag_det <= r_det[DW-1] ? (~r_det + 1'b1) : r_det;
            r_mag_x   <= r_nx[DW-1]  ? (~r_nx + 1'b1)  : r_nx;
            r_mag_y   <= r_ny[DW-1]  ? (~r_ny + 1'b1)  : r_ny;
            r_neg_x   <= r_nx[DW-1] ^ r_det[DW-1];
            r_neg_y   <= r_ny[DW-1] ^ r_det[DW-1];
        end
    end

    always_comb begin
        n_sh_x  = NW'(r_mag_x) << FRAC_BITS;
        n_sh_y  = NW'(r_mag_y) << FRAC_BITS;
        // bits above the quotient window; reaching the divisor means overflow
        n_top_x = n_sh_x >> (COEF_WIDTH + 1);
        n_top_y = n_sh_y >> (COEF_WIDTH + 1);
        n_den_w = NW'(r_mag_det);
        n_flat  = CW'(r_mag_det) <= CW'(i_tol);
        n_coin  = CW'(r_mag_x) <= CW'(i_tol);
        if (!n_flat) begin
            n_side.status = llint_pkg::ST_POINT;
        end else if (n_coin) begin
            n_side.status = llint_pkg::ST_COINCIDENT;
        end else begin
            n_side.status = llint_pkg::ST_PARALLEL;
        end
        n_side.neg_x = r_neg_x;
        n_side.neg_y = r_neg_y;
        n_side.sat_x = n_top_x >= n_den_w;
        n_side.sat_y = n_top_y >= n_den_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_side   <= n_side;
            r_den    <= r_mag_det;
            r_rem_x  <= n_top_x[DW-1:0];
            r_rem_y  <= n_top_y[DW-1:0];
            r_nlow_x <= n_sh_x[COEF_WIDTH:0];
            r_nlow_y <= n_sh_y[COEF_WIDTH:0];
        end
    end

    assign o_side   = r_side;
    assign o_den    = r_den;
    assign o_rem_x  = r_rem_x;
    assign o_rem_y  = r_rem_y;
    assign o_nlow_x = r_nlow_x;
    assign o_nlow_y = r_nlow_y;

endmodule

// ----- rtl/core/llint_div.sv -----
// pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing one divisor; depends on llint_pkg
module llint_div #(
    parameter int COEF_WIDTH = llint_pkg::COEF_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic [COEF_WIDTH:0]    i_en,
    input  llint_pkg::t_side       i_side,
    input  logic [2*COEF_WIDTH:0]  i_den,
    input  logic [2*COEF_WIDTH:0]  i_rem_x,
    input  logic [2*COEF_WIDTH:0]  i_rem_y,
    input  logic [COEF_WIDTH:0]    i_nlow_x,
    input  logic [COEF_WIDTH:0]    i_nlow_y,
    output llint_pkg::t_side       o_side,
    output logic [COEF_WIDTH:0]    o_q_x,
    output logic [COEF_WIDTH:0]    o_q_y
);

    localparam int DW  = 2 * COEF_WIDTH + 1;
    localparam int NST = COEF_WIDTH + 1;

    llint_pkg::t_side     r_side [NST];
    logic [DW-1:0]        r_den   [NST];
    logic [DW-1:0]        r_rem_x [NST];
    logic [DW-1:0]        r_rem_y [NST];
    logic [COEF_WIDTH:0]  r_nl_x  [NST];
    logic [COEF_WIDTH:0]  r_nl_y  [NST];
    logic [COEF_WIDTH:0]  r_q_x   [NST];
    logic [COEF_WIDTH:0]  r_q_y   [NST];

    for (genvar s = 0; s < NST; s++) begin : g_step
        llint_pkg::t_side    w_side;
        logic [DW-1:0]       w_den, w_rem_x, w_rem_y;
        logic [COEF_WIDTH:0] w_nl_x, w_nl_y, w_q_x, w_q_y;
        logic [DW:0]         w_t_x, w_t_y, w_d_x, w_d_y;
        logic                w_ge_x, w_ge_y;

        if (s == 0) begin : g_first
            assign w_side  = i_side;
            assign w_den   = i_den;
            assign w_rem_x = i_rem_x;
            assign w_rem_y = i_rem_y;
            assign w_nl_x  = i_nlow_x;
            assign w_nl_y  = i_nlow_y;
            assign w_q_x   = '0;
            assign w_q_y   = '0;
        end else begin : g_next
            assign w_side  = r_side[s-1];
            assign w_den   = r_den[s-1];
            assign w_rem_x = r_rem_x[s-1];
            assign w_rem_y = r_rem_y[s-1];
            assign w_nl_x  = r_nl_x[s-1];
            assign w_nl_y  = r_nl_y[s-1];
            assign w_q_x   = r_q_x[s-1];
            assign w_q_y   = r_q_y[s-1];
        end

        // bring down the next numerator bit and trial-subtract
        assign w_t_x  = {w_rem_x, w_nl_x[COEF_WIDTH]};
        assign w_t_y  = {w_rem_y, w_nl_y[COEF_WIDTH]};
        assign w_d_x  = w_t_x - {1'b0, w_den};
        assign w_d_y  = w_t_y - {1'b0, w_den};
        assign w_ge_x = w_t_x >= {1'b0, w_den};
        assign w_ge_y = w_t_y >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_side[s]  <= w_side;
                r_den[s]   <= w_den;
                r_nl_x[s]  <= {w_nl_x[COEF_WIDTH-1:0], 1'b0};
                r_nl_y[s]  <= {w_nl_y[COEF_WIDTH-1:0], 1'b0};
                r_rem_x[s] <= w_ge_x ? w_d_x[DW-1:0] : w_t_x[DW-1:0];
                r_rem_y[s] <= w_ge_y ? w_d_y[DW-1:0] : w_t_y[DW-1:0];
                r_q_x[s]   <= {w_q_x[COEF_WIDTH-1:0], w_ge_x};
                r_q_y[s]   <= {w_q_y[COEF_WIDTH-1:0], w_ge_y};
            end
        end
    end

    assign o_side = r_side[NST-1];
    assign o_q_x  = r_q_x[NST-1];
    assign o_q_y  = r_q_y[NST-1];

endmodule

// ----- rtl/core/llint_out.sv -----
// output stage: clamp, sign restore and status masking into the result
// register; depends on llint_pkg
module llint_out #(
    parameter int COEF_WIDTH = llint_pkg::COEF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  llint_pkg::t_side              i_side,
    input  logic [COEF_WIDTH:0]           i_q_x,
    input  logic [COEF_WIDTH:0]           i_q_y,
    output logic [1:0]                    o_status,
    output logic signed [COEF_WIDTH-1:0]  o_x_out,
    output logic signed [COEF_WIDTH-1:0]  o_y_out,
    output logic                          o_saturated
);

    localparam logic [COEF_WIDTH:0] POS_LIM = {2'b00, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH:0] NEG_LIM = {2'b01, {(COEF_WIDTH-1){1'b0}}};

    llint_pkg::t_side          r_status_side;
    logic [COEF_WIDTH-1:0]     r_x, r_y;
    logic                      r_sat;

    logic [COEF_WIDTH:0]       n_lim_x, n_lim_y, n_mag_x, n_mag_y, n_val_x, n_val_y;
    logic                      n_over_x, n_over_y, n_point;

    always_comb begin
        n_lim_x  = i_side.neg_x ? NEG_LIM : POS_LIM;
        n_lim_y  = i_side.neg_y ? NEG_LIM : POS_LIM;
        n_over_x = i_side.sat_x || (i_q_x > n_lim_x);
        n_over_y = i_side.sat_y || (i_q_y > n_lim_y);
        n_mag_x  = n_over_x ? n_lim_x : i_q_x;
        n_mag_y  = n_over_y ? n_lim_y : i_q_y;
        n_val_x  = i_side.neg_x ? (~n_mag_x + 1'b1) : n_mag_x;
        n_val_y  = i_side.neg_y ? (~n_mag_y + 1'b1) : n_mag_y;
        n_point  = i_side.status == llint_pkg::ST_POINT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status_side <= i_side;
            r_x   <= n_point ? n_val_x[COEF_WIDTH-1:0] : '0;
            r_y   <= n_point ? n_val_y[COEF_WIDTH-1:0] : '0;
            r_sat <= n_point && (n_over_x || n_over_y);
        end
    end

    assign o_status    = r_status_side.status;
    assign o_x_out     = r_x;
    assign o_y_out     = r_y;
    assign o_saturated = r_sat;

endmodule

// ----- rtl/core/line_line_intersection.sv -----
// top level of the two-line intersection pipeline: valid chain, tolerance
// register and the front, divider and output stages; depends on llint_pkg
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_a1 i_b1 i_c1 i_a2 i_b2 i_c2
//  result    out        o_valid / i_stall    o_status o_x_out o_y_out o_saturated
//  config    in         i_cfg_we             i_cfg_wdata (tolerance)
//
// one item per cycle while the result channel is not stalled; the divider
// resolves one quotient bit per stage.
// reset clears all stage valid bits and loads tolerance with 1.
// i_stall holds the result register; empty stages still close up behind it,
// so o_stall rises only when every stage holds an item and the output stalls.
module line_line_intersection #(
    parameter int FRAC_BITS  = llint_pkg::FRAC_BITS_DEF,
    parameter int COEF_WIDTH = llint_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COEF_WIDTH-1:0]        i_a1,
    input  logic signed [COEF_WIDTH-1:0]        i_b1,
    input  logic signed [COEF_WIDTH-1:0]        i_c1,
    input  logic signed [COEF_WIDTH-1:0]        i_a2,
    input  logic signed [COEF_WIDTH-1:0]        i_b2,
    input  logic signed [COEF_WIDTH-1:0]        i_c2,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic signed [COEF_WIDTH-1:0]        o_x_out,
    output logic signed [COEF_WIDTH-1:0]        o_y_out,
    output logic                                o_saturated,
    input  logic                                i_cfg_we,
    input  logic [llint_pkg::TOL_WIDTH-1:0]     i_cfg_wdata
);

    localparam int DW  = 2 * COEF_WIDTH + 1;
    localparam int NDV = COEF_WIDTH + 1;
    // four front stages, the divider, one output stage
    localparam int NS  = NDV + 5;

    logic [NS-1:0]                    r_vld, n_vld, w_en;
    logic [llint_pkg::TOL_WIDTH-1:0]  r_tol;

    llint_pkg::t_side     w_f_side, w_d_side;
    logic [DW-1:0]        w_den, w_rem_x, w_rem_y;
    logic [COEF_WIDTH:0]  w_nlow_x, w_nlow_y, w_q_x, w_q_y;

    // a stage may load when the output is free or some stage at or after it is empty
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = !i_stall || !(&r_vld[NS-1:k]);
    end

    assign n_vld = (r_vld & ~w_en) | ({r_vld[NS-2:0], i_valid} & w_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= llint_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NS-1];

    llint_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en[3:0]),
        .i_a1     (i_a1),
        .i_b1     (i_b1),
        .i_c1     (i_c1),
        .i_a2     (i_a2),
        .i_b2     (i_b2),
        .i_c2     (i_c2),
        .i_tol    (r_tol),
        .o_side   (w_f_side),
        .o_den    (w_den),
        .o_rem_x  (w_rem_x),
        .o_rem_y  (w_rem_y),
        .o_nlow_x (w_nlow_x),
        .o_nlow_y (w_nlow_y)
    );

    llint_div #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_en     (w_en[NDV+3:4]),
        .i_side   (w_f_side),
        .i_den    (w_den),
        .i_rem_x  (w_rem_x),
        .i_rem_y  (w_rem_y),
        .i_nlow_x (w_nlow_x),
        .i_nlow_y (w_nlow_y),
        .o_side   (w_d_side),
        .o_q_x    (w_q_x),
        .o_q_y    (w_q_y)
    );

    llint_out #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_en        (w_en[NS-1]),
        .i_side      (w_d_side),
        .i_q_x       (w_q_x),
        .i_q_y       (w_q_y),
        .o_status    (o_status),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_saturated (o_saturated)
    );

endmodule

// ----- rtl/core/llint_checker.sv -----
// port-level checks on the result channel of the intersection pipeline
// depends on llint_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module llint_props #(
    parameter int COEF_WIDTH = llint_pkg::COEF_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_stall,
    input logic                         o_valid,
    input logic [1:0]                   o_status,
    input logic signed [COEF_WIDTH-1:0] o_x_out,
    input logic signed [COEF_WIDTH-1:0] o_y_out,
    input logic                         o_saturated
);

    localparam logic [COEF_WIDTH-1:0] Q_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] Q_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic [2*COEF_WIDTH+2:0] w_res;
    logic                    w_zero;
    logic                    w_pinned;

    assign w_res    = {o_status, o_x_out, o_y_out, o_saturated};
    assign w_zero   = (o_x_out == '0) && (o_y_out == '0) && !o_saturated;
    assign w_pinned = (o_x_out == Q_MAX) || (o_x_out == Q_MIN) ||
                      (o_y_out == Q_MAX) || (o_y_out == Q_MIN);

    // a stalled item holds
    `AST_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(w_res))

    // no intersection point means zero coordinates and no clamp
    `AST_IMP(a_nopoint, i_clk, i_rst_n, o_valid && (o_status != llint_pkg::ST_POINT), w_zero)

    // the clamp flag comes with a coordinate pinned to a range limit
    `AST_IMP(a_clamp, i_clk, i_rst_n, o_valid && o_saturated, w_pinned)

    // reset empties the pipeline
    `AST_NXT_NR(a_rst, i_clk, !i_rst_n, !o_valid)

endmodule

bind line_line_intersection llint_props #(.COEF_WIDTH(COEF_WIDTH)) u_llint_props (.*);
